/* rtl/kwl_pkg.sv */
// Shared types and constants for the keyword token lexer.
`timescale 1ns / 1ps
`default_nettype none

package kwl_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int OFFSET_BITS_MAX = 32;

  // Result queue geometry; the depth is a power of two so the pointers wrap.
  localparam int RES_DEPTH      = 4;
  localparam int RES_PTR_BITS   = 2;
  localparam int RES_LEVEL_BITS = 3;

  typedef logic [7:0] byte_t;

  typedef enum logic [3:0] {
    K_END      = 4'd0,
    K_DOT      = 4'd1,
    K_EQ       = 4'd2,
    K_TILDE_EQ = 4'd3,
    K_LBRACE   = 4'd4,
    K_RBRACE   = 4'd5,
    K_COMMENT  = 4'd6,
    K_OBJECT   = 4'd7,
    K_THREAD   = 4'd8,
    K_SLEEP    = 4'd9,
    K_SLEEPR   = 4'd10,
    K_DUMP     = 4'd11,
    K_IDENT    = 4'd12,
    K_ERROR    = 4'd13
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  // Results caused by one text byte: up to two, slot 0 first.
  typedef struct packed {
    logic [1:0]      count;
    tok_t [1:0]      slot;
  } step_res_t;

  function automatic logic [15:0] sat16(input logic [OFFSET_BITS_MAX-1:0] v);
    return (v > OFFSET_BITS_MAX'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/kwl_result_fifo.sv */
// Small result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps
`default_nettype none

module kwl_result_fifo (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [1:0]                         push_count,
  input  wire kwl_pkg::tok_t [1:0]                push_data,
  input  wire logic                               pop,
  output kwl_pkg::tok_t                           head,
  output logic                                    not_empty,
  output logic [kwl_pkg::RES_LEVEL_BITS-1:0]      level
);
  import kwl_pkg::*;

  typedef logic [RES_PTR_BITS-1:0] ptr_t;

  tok_t mem [RES_DEPTH];
  ptr_t wr_ptr;
  ptr_t rd_ptr;
  ptr_t wr_ptr_1;
  logic [RES_LEVEL_BITS-1:0] level_next;

  assign wr_ptr_1   = wr_ptr + ptr_t'(1);
  assign head       = mem[rd_ptr];
  assign not_empty  = (level != '0);
  assign level_next = level + RES_LEVEL_BITS'(push_count) - RES_LEVEL_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_data[0];
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_1] <= push_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ptr_t'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + ptr_t'(1);
      end
      level <= level_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/kwl_core.sv */
// Lexer state and per-byte token logic.
`timescale 1ns / 1ps
`default_nettype none

module kwl_core #(
  parameter int OFFSET_BITS = kwl_pkg::OFFSET_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         text_char,
  input  wire logic               fire,
  output kwl_pkg::step_res_t      res
);
  import kwl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_SLASH   = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_TILDE   = 3'd4
  } scan_mode_t;

  typedef logic [OFFSET_BITS-1:0] off_t;

  localparam off_t OFFSET_MAX = '1;

  localparam byte_t CH_NL     = 8'h0a;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_CR     = 8'h0d;
  localparam byte_t CH_DOT    = 8'h2e;
  localparam byte_t CH_SLASH  = 8'h2f;
  localparam byte_t CH_EQ     = 8'h3d;
  localparam byte_t CH_LBRACE = 8'h7b;
  localparam byte_t CH_RBRACE = 8'h7d;
  localparam byte_t CH_TILDE  = 8'h7e;
  localparam byte_t CH_END    = 8'h00;

  localparam logic [47:0] KW_OBJECT = 48'("object");
  localparam logic [47:0] KW_THREAD = 48'("thread");
  localparam logic [47:0] KW_SLEEP  = 48'("sleep");
  localparam logic [47:0] KW_SLEEPR = 48'("sleepr");
  localparam logic [47:0] KW_DUMP   = 48'("dump");

  scan_mode_t  scan_mode, scan_mode_next;
  off_t        text_offset, text_offset_next;
  off_t        pending_start, pending_start_next;
  logic [47:0] word_prefix, word_prefix_next;
  logic [2:0]  word_count, word_count_next;

  logic        is_alpha, is_alnum, is_space, is_end;
  logic        fresh;
  logic        pend_v, fr_v;
  token_kind_t pend_kind, fr_kind;
  off_t        pend_len;
  logic [15:0] fr_len;
  tok_t        pend_tok, fr_tok;

  function automatic token_kind_t classify(input logic [47:0] p, input logic [2:0] n);
    token_kind_t k;
    k = K_IDENT;
    if (n == 3'd6 && p == KW_OBJECT) k = K_OBJECT;
    else if (n == 3'd6 && p == KW_THREAD) k = K_THREAD;
    else if (n == 3'd5 && p == KW_SLEEP) k = K_SLEEP;
    else if (n == 3'd6 && p == KW_SLEEPR) k = K_SLEEPR;
    else if (n == 3'd4 && p == KW_DUMP) k = K_DUMP;
    return k;
  endfunction

  assign is_alpha = (text_char >= 8'h61 && text_char <= 8'h7a) ||
                    (text_char >= 8'h41 && text_char <= 8'h5a);
  assign is_alnum = is_alpha || (text_char >= 8'h30 && text_char <= 8'h39);
  assign is_space = (text_char == CH_SPACE) || (text_char >= CH_TAB && text_char <= CH_CR);
  assign is_end   = (text_char == CH_END);

  always_comb begin
    scan_mode_next     = scan_mode;
    pending_start_next = pending_start;
    word_prefix_next   = word_prefix;
    word_count_next    = word_count;
    fresh     = 1'b1;
    pend_v    = 1'b0;
    pend_kind = K_ERROR;
    pend_len  = off_t'(1);
    fr_v      = 1'b0;
    fr_kind   = K_ERROR;
    fr_len    = 16'd1;

    // Close or extend the token in progress.
    unique case (scan_mode)
      MODE_WORD: begin
        if (is_alnum) begin
          if (word_count < 3'd6) begin
            word_prefix_next = {word_prefix[39:0], text_char};
          end
          if (word_count < 3'd7) begin
            word_count_next = word_count + 3'd1;
          end
          fresh = 1'b0;
        end else begin
          pend_v    = 1'b1;
          pend_kind = classify(word_prefix, word_count);
          pend_len  = text_offset - pending_start;
        end
      end
      MODE_SLASH: begin
        if (text_char == CH_SLASH) begin
          scan_mode_next = MODE_COMMENT;
          fresh = 1'b0;
        end else begin
          pend_v = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (!is_end && text_char != CH_NL) begin
          fresh = 1'b0;
        end else begin
          pend_v    = 1'b1;
          pend_kind = K_COMMENT;
          pend_len  = text_offset - pending_start;
        end
      end
      MODE_TILDE: begin
        pend_v = 1'b1;
        if (text_char == CH_EQ) begin
          pend_kind      = K_TILDE_EQ;
          pend_len       = off_t'(2);
          scan_mode_next = MODE_IDLE;
          fresh          = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Lex the byte as the start of something new.
    if (fresh) begin
      scan_mode_next = MODE_IDLE;
      if (is_end) begin
        fr_v    = 1'b1;
        fr_kind = K_END;
        fr_len  = 16'd0;
      end else if (is_space) begin
        fr_v = 1'b0;
      end else if (text_char == CH_DOT) begin
        fr_v    = 1'b1;
        fr_kind = K_DOT;
      end else if (text_char == CH_EQ) begin
        fr_v    = 1'b1;
        fr_kind = K_EQ;
      end else if (text_char == CH_LBRACE) begin
        fr_v    = 1'b1;
        fr_kind = K_LBRACE;
      end else if (text_char == CH_RBRACE) begin
        fr_v    = 1'b1;
        fr_kind = K_RBRACE;
      end else if (text_char == CH_TILDE) begin
        scan_mode_next     = MODE_TILDE;
        pending_start_next = text_offset;
      end else if (text_char == CH_SLASH) begin
        scan_mode_next     = MODE_SLASH;
        pending_start_next = text_offset;
      end else if (is_alpha) begin
        scan_mode_next     = MODE_WORD;
        pending_start_next = text_offset;
        word_prefix_next   = 48'(text_char);
        word_count_next    = 3'd1;
      end else begin
        fr_v = 1'b1;
      end
    end

    // End of text: rewind for the next text.
    if (is_end) begin
      text_offset_next = '0;
      scan_mode_next   = MODE_IDLE;
      word_prefix_next = '0;
      word_count_next  = '0;
    end else if (text_offset < OFFSET_MAX) begin
      text_offset_next = text_offset + off_t'(1);
    end else begin
      text_offset_next = text_offset;
    end
  end

  always_comb begin
    pend_tok.kind   = pend_kind;
    pend_tok.start  = sat16(OFFSET_BITS_MAX'(pending_start));
    pend_tok.length = sat16(OFFSET_BITS_MAX'(pend_len));
    pend_tok.last   = !fr_v;
    fr_tok.kind     = fr_kind;
    fr_tok.start    = sat16(OFFSET_BITS_MAX'(text_offset));
    fr_tok.length   = fr_len;
    fr_tok.last     = 1'b1;

    res.count = 2'(pend_v) + 2'(fr_v);
    if (pend_v) begin
      res.slot[0] = pend_tok;
      res.slot[1] = fr_tok;
    end else begin
      res.slot[0] = fr_tok;
      res.slot[1] = fr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      text_offset   <= '0;
      pending_start <= '0;
      word_prefix   <= '0;
      word_count    <= '0;
    end else if (fire) begin
      scan_mode     <= scan_mode_next;
      text_offset   <= text_offset_next;
      pending_start <= pending_start_next;
      word_prefix   <= word_prefix_next;
      word_count    <= word_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/keyword_token_lexer.sv */
// Keyword token lexer: input byte register, lexer core and result queue.
// Path: byte register, then combinational lexing in the core, then the result queue.
// Throughput: one byte per cycle while the queue has room; queued tokens leave one at a time.
// The four-entry result queue decouples the sides; input stalls only when it lacks room.
// Reset: synchronous, clears offset, scan mode, word state, byte valid flag and the queue.
`timescale 1ns / 1ps
`default_nettype none

module keyword_token_lexer #(
  parameter int OFFSET_BITS = kwl_pkg::OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        text_valid,
  output logic             text_stall,
  input  wire logic [7:0]  text_char,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [3:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic             last_of_run
);
  import kwl_pkg::*;

  logic                      hold_valid;
  byte_t                     hold_char;
  step_res_t                 res;
  logic                      fire;
  logic                      pop;
  tok_t                      head;
  logic [RES_LEVEL_BITS-1:0] level;
  logic [RES_LEVEL_BITS-1:0] room;

  // Advance the held byte only when the queue can take all its tokens.
  assign room       = RES_LEVEL_BITS'(RES_DEPTH) - level;
  assign fire       = hold_valid && (RES_LEVEL_BITS'(res.count) <= room);
  assign text_stall = hold_valid && !fire;
  assign pop        = token_valid && !token_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!text_stall) begin
      hold_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      hold_char <= text_char;
    end
  end

  kwl_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .text_char(hold_char),
    .fire     (fire),
    .res      (res)
  );

  kwl_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(fire ? res.count : 2'd0),
    .push_data (res.slot),
    .pop       (pop),
    .head      (head),
    .not_empty (token_valid),
    .level     (level)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= RES_LEVEL_BITS'(RES_DEPTH))
    else $error("result queue overfilled");

  a_end_zero_len: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_kind == K_END) |-> (token_length == 16'd0 && last_of_run))
    else $error("end token with length or not last");

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> (hold_valid && level > RES_LEVEL_BITS'(RES_DEPTH - 2)))
    else $error("input stalled with room in the queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !token_valid)
    else $error("tokens present after reset");
`endif

endmodule

`default_nettype wire
